FILE: rtl/assert_macros.svh
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, prop, msg)
`endif
`endif

FILE: rtl/mps_pkg.sv
// Types and constants of the multi-policy scheduler.
package mps_pkg;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [2:0] POL_FCFS  = 3'd0;
   localparam logic [2:0] POL_SJF   = 3'd1;
   localparam logic [2:0] POL_PRIO  = 3'd2;
   localparam logic [2:0] POL_RR    = 3'd3;
   localparam logic [2:0] POL_SRTF  = 3'd4;
   localparam logic [2:0] POL_PPRIO = 3'd5;

   localparam logic [1:0] REG_POLICY = 2'd0;
   localparam logic [1:0] REG_SLICE  = 2'd1;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] total;
      logic [15:0] remain;
      logic [7:0]  prio;
   } job_type;

   typedef struct packed {
      logic       queue_full;
      logic       idle;
      logic       picked_valid;
      logic [7:0] picked_id;
      logic       finished_valid;
      logic [7:0] finished_id;
      logic       requeue_valid;
      logic [7:0] requeue_id;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH,
      ST_SHIFT,
      ST_HEAD,
      ST_EXEC,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/multi_policy_cpu_scheduler.sv
// Multi-policy single-CPU scheduler top level.
// Request channel (req_*): command 0 appends a job to the ready queue, command 1
// advances time by one tick. One response (rsp_*) follows every request.
// Config (csr_*): index 0 policy, index 1 round robin slice; always ready,
// write only while no request is in flight.
// Flow: an arrive passes from the idle state through the done state to the response
// register. A tick whose CPU is busy passes through the head, exec and done states; a
// tick that picks a job first scans the queue with one comparator (the whole queue for
// the minimum-search policies, only the head otherwise) and then compacts it before the
// head, exec and done states. The queue memory read port is registered.
// The block handles one request at a time: req_stall is high from acceptance
// until the response is loaded into the output register.
// A stalled response holds; the block waits with its result until rsp_stall falls.
// Reset empties the queue, clears the CPU, sets policy 0 and slice 4.
module multi_policy_cpu_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_job_id,
   input  logic [15:0] req_job_burst,
   input  logic [7:0]  req_job_priority,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_queue_full,
   output logic        rsp_idle,
   output logic        rsp_picked_valid,
   output logic [7:0]  rsp_picked_id,
   output logic        rsp_finished_valid,
   output logic [7:0]  rsp_finished_id,
   output logic        rsp_requeue_valid,
   output logic [7:0]  rsp_requeue_id,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import mps_pkg::*;
`include "assert_macros.svh"

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic run_valid_ff, run_valid_in;
   job_type run_ff, run_in;
   logic [7:0] slice_ff, slice_in;
   logic [2:0] policy_ff, policy_in;
   logic [7:0] tslice_ff, tslice_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic pend_ff, pend_in;
   logic [CNT_W-1:0] pidx_ff, pidx_in;
   job_type best_ff, best_in;
   logic [CNT_W-1:0] bidx_ff, bidx_in;
   result_type res_ff, res_in;
   result_type out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   job_type wr_data, rd_data;

   logic req_take, out_free, min_pol, by_total, scan_done, shift_done;
   logic [CNT_W-1:0] limit;
   logic [15:0] cmp_a, cmp_b;
   logic cmp_lt;
   job_type run_next;
   logic [7:0] slice_next;
   logic preempt;

   mps_queue #(.DEPTH(QUEUE_DEPTH), .IDX_W(IDX_W)) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign by_total   = (policy_ff == POL_SJF) || (policy_ff == POL_SRTF);
   assign min_pol    = by_total || (policy_ff == POL_PRIO) || (policy_ff == POL_PPRIO);
   assign limit      = min_pol ? count_ff : ONE;
   assign scan_done  = (ptr_ff >= limit) && !pend_ff;
   assign shift_done = (ptr_ff >= count_ff) && !pend_ff;

   // shared comparator
   always_comb begin
      cmp_a = 16'd0;
      cmp_b = 16'd0;
      if (state_ff == ST_SRCH) begin
         cmp_a = by_total ? rd_data.total : {8'd0, rd_data.prio};
         cmp_b = by_total ? best_ff.total : {8'd0, best_ff.prio};
      end else if (policy_ff == POL_SRTF) begin
         cmp_a = rd_data.remain;
         cmp_b = run_next.remain;
      end else begin
         cmp_a = {8'd0, rd_data.prio};
         cmp_b = {8'd0, run_ff.prio};
      end
   end
   assign cmp_lt = cmp_a < cmp_b;

   always_comb begin
      run_next = run_ff;
      if (run_ff.remain != 16'd0) begin
         run_next.remain = run_ff.remain - 16'd1;
      end
      slice_next = slice_ff + 8'd1;
      unique case (policy_ff)
         POL_RR:    preempt = (slice_next == tslice_ff);
         POL_SRTF,
         POL_PPRIO: preempt = (count_ff != '0) && cmp_lt;
         default:   preempt = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_command == CMD_ARRIVE) state_in = ST_DONE;
               else if (run_valid_ff)         state_in = ST_HEAD;
               else if (count_ff == '0)       state_in = ST_DONE;
               else                           state_in = ST_SRCH;
            end
         end
         ST_SRCH:  if (scan_done) state_in = ST_SHIFT;
         ST_SHIFT: if (shift_done) state_in = ST_HEAD;
         ST_HEAD:  state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      count_in     = count_ff;
      run_valid_in = run_valid_ff;
      run_in       = run_ff;
      slice_in     = slice_ff;
      policy_in    = policy_ff;
      tslice_in    = tslice_ff;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      best_in      = best_ff;
      bidx_in      = bidx_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = run_next;
      rd_addr      = ptr_ff[IDX_W-1:0];

      if (csr_valid && csr_ready) begin
         if (csr_index == REG_POLICY)     policy_in = csr_data[2:0];
         else if (csr_index == REG_SLICE) tslice_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            res_in = '0;
            ptr_in = '0;
            if (req_take) begin
               if (req_command == CMD_ARRIVE) begin
                  if (count_ff == FULL) begin
                     res_in.queue_full = 1'b1;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = '{id: req_job_id, total: req_job_burst,
                                 remain: req_job_burst, prio: req_job_priority};
                     count_in = count_ff + ONE;
                  end
               end else if (!run_valid_ff && count_ff == '0) begin
                  res_in.idle = 1'b1;
               end
            end
         end
         ST_SRCH: begin
            if (ptr_ff < limit) begin
               ptr_in  = ptr_ff + ONE;
               pend_in = 1'b1;
               pidx_in = ptr_ff;
            end
            if (pend_ff && (pidx_ff == '0 || cmp_lt)) begin
               best_in = rd_data;
               bidx_in = pidx_ff;
            end
            if (scan_done) begin
               run_in       = best_ff;
               run_valid_in = 1'b1;
               slice_in     = 8'd0;
               res_in.picked_valid = 1'b1;
               res_in.picked_id    = best_ff.id;
               ptr_in = bidx_ff + ONE;
            end
         end
         ST_SHIFT: begin
            if (ptr_ff < count_ff) begin
               ptr_in  = ptr_ff + ONE;
               pend_in = 1'b1;
               pidx_in = ptr_ff;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(pidx_ff - ONE);
               wr_data = rd_data;
            end
            if (shift_done) count_in = count_ff - ONE;
         end
         ST_HEAD: begin
            rd_addr = '0;
         end
         ST_EXEC: begin
            run_in   = run_next;
            slice_in = slice_next;
            if (run_next.remain == 16'd0) begin
               res_in.finished_valid = 1'b1;
               res_in.finished_id    = run_ff.id;
               run_valid_in = 1'b0;
               slice_in     = 8'd0;
            end else if (preempt && count_ff != FULL) begin
               wr_en    = 1'b1;
               count_in = count_ff + ONE;
               res_in.requeue_valid = 1'b1;
               res_in.requeue_id    = run_ff.id;
               run_valid_in = 1'b0;
               slice_in     = 8'd0;
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_DONE && out_free) begin
         out_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         run_valid_ff <= 1'b0;
         run_ff       <= '0;
         slice_ff     <= 8'd0;
         policy_ff    <= POL_FCFS;
         tslice_ff    <= 8'd4;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         run_valid_ff <= run_valid_in;
         run_ff       <= run_in;
         slice_ff     <= slice_in;
         policy_ff    <= policy_in;
         tslice_ff    <= tslice_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff  <= ptr_in;
      pidx_ff <= pidx_in;
      best_ff <= best_in;
      bidx_ff <= bidx_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_queue_full     = out_ff.queue_full;
   assign rsp_idle           = out_ff.idle;
   assign rsp_picked_valid   = out_ff.picked_valid;
   assign rsp_picked_id      = out_ff.picked_id;
   assign rsp_finished_valid = out_ff.finished_valid;
   assign rsp_finished_id    = out_ff.finished_id;
   assign rsp_requeue_valid  = out_ff.requeue_valid;
   assign rsp_requeue_id     = out_ff.requeue_id;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL, "queue count overflow")
   `ASSERT_ALWAYS(a_exec_running, clock, reset, (state_ff == ST_EXEC) |-> run_valid_ff, "exec without job")
   `ASSERT_NEVER(a_fin_requeue, clock, reset, rsp_valid && rsp_finished_valid && rsp_requeue_valid, "finish and requeue")
   `ASSERT_NEVER(a_idle_pick, clock, reset, rsp_valid && rsp_idle && rsp_picked_valid, "idle and pick")

endmodule

FILE: rtl/mps_queue.sv
// Ready queue storage: one write port, one registered read port.
module mps_queue #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  mps_pkg::job_type wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output mps_pkg::job_type rd_data
);
   import mps_pkg::*;

   job_type mem [DEPTH];
   job_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/mps_checker.sv
// Checker for the multi-policy scheduler: predicts each response and compares it.
module mps_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_job_id,
   input  logic [15:0] req_job_burst,
   input  logic [7:0]  req_job_priority,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_queue_full,
   input  logic        rsp_idle,
   input  logic        rsp_picked_valid,
   input  logic [7:0]  rsp_picked_id,
   input  logic        rsp_finished_valid,
   input  logic [7:0]  rsp_finished_id,
   input  logic        rsp_requeue_valid,
   input  logic [7:0]  rsp_requeue_id,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          pending
);
   import mps_pkg::*;

   job_type    ready_q[$];
   logic       cpu_busy;
   job_type    cpu_job;
   logic [7:0] slice_cnt;
   logic [2:0] cur_policy;
   logic [7:0] cur_slice;
   result_type sched_expect[$];

   function automatic int pick_index();
      int best;
      best = 0;
      for (int i = 1; i < ready_q.size(); i++) begin
         if ((cur_policy == POL_SJF || cur_policy == POL_SRTF) &&
             ready_q[i].total < ready_q[best].total)
            best = i;
         if ((cur_policy == POL_PRIO || cur_policy == POL_PPRIO) &&
             ready_q[i].prio < ready_q[best].prio)
            best = i;
      end
      return best;
   endfunction

   task automatic schedule_step(input logic cmd, input job_type arr, output result_type r);
      int idx;
      logic preempt;
      r = '0;
      if (cmd == CMD_ARRIVE) begin
         if (ready_q.size() >= QUEUE_DEPTH) r.queue_full = 1'b1;
         else ready_q.push_back(arr);
         return;
      end
      if (!cpu_busy) begin
         if (ready_q.size() == 0) r.idle = 1'b1;
         else begin
            idx = pick_index();
            cpu_job = ready_q[idx];
            ready_q.delete(idx);
            cpu_busy = 1'b1;
            slice_cnt = '0;
            r.picked_valid = 1'b1;
            r.picked_id = cpu_job.id;
         end
      end
      if (cpu_busy) begin
         preempt = 1'b0;
         if (cpu_job.remain != 16'd0) cpu_job.remain = cpu_job.remain - 16'd1;
         slice_cnt = slice_cnt + 8'd1;
         if (cpu_job.remain == 16'd0) begin
            r.finished_valid = 1'b1;
            r.finished_id = cpu_job.id;
            cpu_busy = 1'b0;
            slice_cnt = '0;
         end else begin
            if (cur_policy == POL_RR) preempt = (slice_cnt == cur_slice);
            else if (cur_policy == POL_SRTF)
               preempt = ready_q.size() > 0 && ready_q[0].remain < cpu_job.remain;
            else if (cur_policy == POL_PPRIO)
               preempt = ready_q.size() > 0 && ready_q[0].prio < cpu_job.prio;
            if (preempt && ready_q.size() < QUEUE_DEPTH) begin
               ready_q.push_back(cpu_job);
               r.requeue_valid = 1'b1;
               r.requeue_id = cpu_job.id;
               cpu_busy = 1'b0;
               slice_cnt = '0;
            end
         end
      end
   endtask

   assign pending = sched_expect.size();

   always @(posedge clock) begin
      job_type    arr;
      result_type r, got;
      if (reset) begin
         ready_q.delete();
         sched_expect.delete();
         cpu_busy = 1'b0;
         cpu_job = '0;
         slice_cnt = '0;
         cur_policy = POL_FCFS;
         cur_slice = 8'd4;
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_POLICY) cur_policy = csr_data[2:0];
            else if (csr_index == REG_SLICE) cur_slice = csr_data;
         end
         if (req_valid && !req_stall) begin
            arr.id = req_job_id;
            arr.total = req_job_burst;
            arr.remain = req_job_burst;
            arr.prio = req_job_priority;
            schedule_step(req_command, arr, r);
            sched_expect.push_back(r);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_queue_full, rsp_idle, rsp_picked_valid, rsp_picked_id,
                    rsp_finished_valid, rsp_finished_id, rsp_requeue_valid,
                    rsp_requeue_id};
            if (sched_expect.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               r = sched_expect.pop_front();
               if (got != r) begin
                  $display("%0t: mismatch expected %h actual %h", $time, r, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: tb/tb_top.sv
// Top of the scheduler testbench: drives requests and config, gives the verdict.
module tb_top;
   import mps_pkg::*;

   localparam int DEPTH = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [7:0]  req_job_id = '0;
   logic [15:0] req_job_burst = 16'd1;
   logic [7:0]  req_job_priority = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_queue_full, rsp_idle, rsp_picked_valid, rsp_finished_valid;
   logic        rsp_requeue_valid;
   logic [7:0]  rsp_picked_id, rsp_finished_id, rsp_requeue_id;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;
   int          fail_count, pending;
   int          cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   multi_policy_cpu_scheduler #(.QUEUE_DEPTH(DEPTH)) dut (.*);
   mps_checker #(.QUEUE_DEPTH(DEPTH)) chk (.*);

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // response-side stalls
   initial begin
      int burst_mode;
      @(posedge clock iff !reset);
      forever begin
         burst_mode = ($urandom_range(0, 9) < 3);
         repeat (40) begin
            rsp_stall <= burst_mode ? 1'b0 : (gap_len() != 0);
            @(posedge clock);
         end
      end
   end

   task automatic send(input logic cmd, input logic [7:0] id, input logic [15:0] burst,
                       input logic [7:0] prio, input bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      repeat (g) @(posedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_job_id <= id;
      req_job_burst <= burst;
      req_job_priority <= prio;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic arrive(input logic [7:0] id, input logic [15:0] burst,
                         input logic [7:0] prio);
      send(CMD_ARRIVE, id, burst, prio, 1'b1);
   endtask

   task automatic tick();
      send(CMD_TICK, 8'($urandom), 16'($urandom), 8'($urandom), 1'b1);
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [2:0] pol;
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty tick, field extremes, full queue, zero burst
      tick();
      arrive(8'hFF, 16'hFFFF, 8'hFF);
      arrive(8'h00, 16'd1, 8'h00);
      arrive(8'h5A, 16'd0, 8'h80);
      for (int i = 0; i < DEPTH; i++) arrive(8'(i + 16), 16'd2, 8'(i));
      repeat (6) tick();
      write_reg(REG_POLICY, {5'd0, POL_SJF});
      write_reg(REG_SLICE, 8'd0);
      repeat (4) tick();

      for (int ph = 0; ph < 16; ph++) begin
         pol = (ph < 8) ? ph[2:0] : 3'($urandom_range(0, 7));
         write_reg(REG_POLICY, {5'd0, pol});
         case (ph % 4)
            0: write_reg(REG_SLICE, 8'd1);
            1: write_reg(REG_SLICE, 8'd255);
            default: write_reg(REG_SLICE, 8'($urandom_range(1, 6)));
         endcase
         n = 0;
         while (n < 45) begin
            if ($urandom_range(0, 99) < 45)
               arrive(8'($urandom),
                      ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
            else tick();
            n++;
         end
         if (ph == 5) drain();
      end
      // flush running work
      repeat (40) tick();

      drain();
      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mps_pkg.sv
rtl/mps_queue.sv
rtl/multi_policy_cpu_scheduler.sv
tb/mps_checker.sv
tb/tb_top.sv
